// ===== rtl/core/mtsc_pkg.sv =====
// Shared types and constants for the min-threshold strong-connectivity core.
`default_nettype none

package mtsc_pkg;

    localparam int MAX_NODES_DEFAULT = 64;
    localparam int WEIGHT_W          = 32;
    localparam int THR_W             = 31;
    localparam int CNT_W             = 7;
    localparam int PADDR_W           = 2;
    localparam int DATA_W            = 32;

    localparam logic [THR_W-1:0]   TOP_THRESHOLD    = 31'h7FFF_FFFF;
    localparam logic [CNT_W-1:0]   NODE_COUNT_RESET = 7'd1;
    localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT  = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_POP,
        ST_SCAN,
        ST_DRAIN,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic load;
        logic search_init;
        logic round_start;
        logic walk_start;
        logic walk_rev;
        logic pop;
        logic scan_issue;
        logic pass;
        logic fail;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic round_done;
        logic stack_empty;
        logic scan_last;
        logic walk_ok;
        logic rev_phase;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/min_threshold_strong_connectivity_core.sv =====
// Top level of the min-threshold strong-connectivity core: config port and core wiring.
`default_nettype none

// Channel   Words                       Handshake              Direction
// -------   -------------------------   --------------------   ---------
// config    node_count (APB, addr 0)    psel/penable/pready    in
// input     edge_weight, last_entry     in_valid / in_stall    in
// output    threshold                   out_valid / out_stall  out
//
// Input words load the matrix row by row at stride node_count while in_stall is low.
// The word with last_entry set starts the search: about 31 rounds, each a forward
// walk and, when that reaches every node, a reversed walk; the single read port of
// the weight memory limits a walk to one matrix entry per cycle while it scans.
// Reset clears all control state at once; the weight memory needs no clearing pass.
// in_stall stays high for the whole search; the result sits in an output register,
// so a stalled result only holds off the final hand-over of the next search.

module min_threshold_strong_connectivity_core #(
    parameter int MAX_NODES = mtsc_pkg::MAX_NODES_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mtsc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mtsc_pkg::DATA_W-1:0]    pwdata,
    output logic      [mtsc_pkg::DATA_W-1:0]    prdata,
    output logic                                pready,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [mtsc_pkg::WEIGHT_W-1:0]  edge_weight,
    input  wire logic                           last_entry,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [mtsc_pkg::THR_W-1:0]     threshold
);

    logic [mtsc_pkg::CNT_W-1:0] node_count_reg;
    logic [mtsc_pkg::CNT_W-1:0] node_count_next;
    logic                       cfg_write;

    mtsc_pkg::cmd_t    cmd;
    mtsc_pkg::status_t status;

    // APB: no wait states; write lands on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        node_count_next = node_count_reg;
        if (cfg_write && (paddr == mtsc_pkg::ADDR_NODE_COUNT))
        begin
            node_count_next = pwdata[mtsc_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= mtsc_pkg::NODE_COUNT_RESET;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    // read back the raw register; clamping to 1..MAX_NODES happens in the datapath
    always_comb
    begin
        if (paddr == mtsc_pkg::ADDR_NODE_COUNT)
        begin
            prdata = {{(mtsc_pkg::DATA_W - mtsc_pkg::CNT_W){1'b0}}, node_count_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // sequence loads, rounds, walks and the result hand-over
    mtsc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_entry (last_entry),
        .status     (status),
        .cmd        (cmd),
        .in_stall   (in_stall)
    );

    // store the matrix, walk it and keep the search bounds
    mtsc_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .node_count  (node_count_reg),
        .edge_weight (edge_weight),
        .cmd         (cmd),
        .out_stall   (out_stall),
        .status      (status),
        .out_valid   (out_valid),
        .threshold   (threshold)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mtsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mtsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mtsc_ctrl.sv =====
// Controller state machine: sequences loading, search rounds and graph walks.
`default_nettype none

module mtsc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             last_entry,
    input  wire mtsc_pkg::status_t status,
    output mtsc_pkg::cmd_t        cmd,
    output logic                  in_stall
);

    mtsc_pkg::state_t state_reg;
    mtsc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtsc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtsc_pkg::ST_IDLE:
            begin
                if (in_valid && last_entry)
                begin
                    state_next = mtsc_pkg::ST_ROUND;
                end
            end
            mtsc_pkg::ST_ROUND:
            begin
                if (status.round_done)
                begin
                    if (status.out_free)
                    begin
                        state_next = mtsc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = mtsc_pkg::ST_POP;
                end
            end
            mtsc_pkg::ST_POP:
            begin
                state_next = status.stack_empty ? mtsc_pkg::ST_CHECK : mtsc_pkg::ST_SCAN;
            end
            mtsc_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = mtsc_pkg::ST_DRAIN;
                end
            end
            mtsc_pkg::ST_DRAIN:
            begin
                state_next = mtsc_pkg::ST_POP;
            end
            mtsc_pkg::ST_CHECK:
            begin
                if (status.walk_ok && !status.rev_phase)
                begin
                    state_next = mtsc_pkg::ST_POP;
                end
                else
                begin
                    state_next = mtsc_pkg::ST_ROUND;
                end
            end
            default:
            begin
                state_next = mtsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            mtsc_pkg::ST_IDLE:
            begin
                in_stall        = 1'b0;
                cmd.load        = in_valid;
                cmd.search_init = in_valid && last_entry;
            end
            mtsc_pkg::ST_ROUND:
            begin
                if (status.round_done)
                begin
                    cmd.out_load = status.out_free;
                end
                else
                begin
                    cmd.round_start = 1'b1;
                    cmd.walk_start  = 1'b1;
                    cmd.walk_rev    = 1'b0;
                end
            end
            mtsc_pkg::ST_POP:
            begin
                cmd.pop = !status.stack_empty;
            end
            mtsc_pkg::ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            mtsc_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            mtsc_pkg::ST_CHECK:
            begin
                if (status.walk_ok && !status.rev_phase)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_rev   = 1'b1;
                end
                else if (status.walk_ok)
                begin
                    cmd.pass = 1'b1;
                end
                else
                begin
                    cmd.fail = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/mtsc_datapath.sv =====
// Datapath: weight store, walk stack, visited marks, search bounds, result register.
`default_nettype none

module mtsc_datapath #(
    parameter int MAX_NODES = mtsc_pkg::MAX_NODES_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [mtsc_pkg::CNT_W-1:0]  node_count,
    input  wire logic [mtsc_pkg::WEIGHT_W-1:0] edge_weight,
    input  wire mtsc_pkg::cmd_t              cmd,
    input  wire logic                        out_stall,
    output mtsc_pkg::status_t                status,
    output logic                             out_valid,
    output logic [mtsc_pkg::THR_W-1:0]       threshold
);

    localparam int NODE_W = $clog2(MAX_NODES + 1);
    localparam int NID_W  = $clog2(MAX_NODES);
    localparam int IDX_W  = $clog2(MAX_NODES * MAX_NODES + 1);
    localparam int ADDR_W = $clog2(MAX_NODES * MAX_NODES);
    localparam int THR_W  = mtsc_pkg::THR_W;
    localparam int WGT_W  = mtsc_pkg::WEIGHT_W;

    // active node count and matrix size
    logic [NODE_W-1:0] nodes;
    logic [IDX_W-1:0]  nodes_ext;
    logic [IDX_W-1:0]  total;

    always_comb
    begin
        if (node_count == '0)
        begin
            nodes = NODE_W'(1);
        end
        else if (32'(node_count) > 32'(MAX_NODES))
        begin
            nodes = NODE_W'(MAX_NODES);
        end
        else
        begin
            nodes = NODE_W'(node_count);
        end
    end

    assign nodes_ext = IDX_W'(nodes);
    assign total     = nodes_ext * nodes_ext;

    // control registers
    logic [IDX_W-1:0]     load_index_reg, load_index_next;
    logic [THR_W-1:0]     low_reg, low_next;
    logic [THR_W-1:0]     high_reg, high_next;
    logic                 rev_reg, rev_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [NODE_W-1:0]    depth_reg, depth_next;
    logic [NODE_W-1:0]    seen_reg, seen_next;
    logic                 eval_valid_reg, eval_valid_next;
    logic                 out_valid_reg, out_valid_next;

    // payload registers
    logic [THR_W-1:0]     mid_reg, mid_next;
    logic [NID_W-1:0]     j_reg, j_next;
    logic [NID_W-1:0]     eval_j_reg, eval_j_next;
    logic [THR_W-1:0]     thr_reg, thr_next;

    logic                 load_we;
    logic [NID_W-1:0]     cur_node;
    logic [IDX_W-1:0]     row_ext;
    logic [IDX_W-1:0]     col_ext;
    logic [IDX_W-1:0]     edge_index;
    logic [WGT_W-1:0]     w_rdata;
    logic                 kept;
    logic                 push;
    logic                 stack_we;
    logic [NID_W-1:0]     stack_waddr;
    logic [NID_W-1:0]     stack_wdata;
    logic [NID_W-1:0]     stack_raddr;

    assign load_we = cmd.load && (load_index_reg < total);

    // edge (row, col): forward walk reads row cur_node, reversed reads column cur_node
    assign row_ext    = rev_reg ? IDX_W'(j_reg) : IDX_W'(cur_node);
    assign col_ext    = rev_reg ? IDX_W'(cur_node) : IDX_W'(j_reg);
    assign edge_index = row_ext * nodes_ext + col_ext;

    // negative weights always pass the non-negative bound
    assign kept = w_rdata[WGT_W-1] || (w_rdata[THR_W-1:0] <= mid_reg);
    assign push = eval_valid_reg && kept && !visited_reg[eval_j_reg];

    assign stack_we    = cmd.walk_start || push;
    assign stack_waddr = cmd.walk_start ? '0 : depth_reg[NID_W-1:0];
    assign stack_wdata = cmd.walk_start ? '0 : eval_j_reg;
    assign stack_raddr = NID_W'(depth_reg - NODE_W'(1));

    mtsc_ram #(
        .WIDTH (WGT_W),
        .DEPTH (MAX_NODES * MAX_NODES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_index_reg[ADDR_W-1:0]),
        .wdata (edge_weight),
        .re    (cmd.scan_issue),
        .raddr (edge_index[ADDR_W-1:0]),
        .rdata (w_rdata)
    );

    mtsc_ram #(
        .WIDTH (NID_W),
        .DEPTH (MAX_NODES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (cmd.pop),
        .raddr (stack_raddr),
        .rdata (cur_node)
    );

    always_comb
    begin
        load_index_next = load_index_reg;
        if (cmd.search_init)
        begin
            load_index_next = '0;
        end
        else if (cmd.load)
        begin
            load_index_next = (load_index_reg < total) ? load_index_reg + IDX_W'(1) : total;
        end
    end

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        mid_next  = mid_reg;
        if (cmd.search_init)
        begin
            low_next  = '0;
            high_next = mtsc_pkg::TOP_THRESHOLD;
        end
        else if (cmd.pass)
        begin
            high_next = mid_reg;
        end
        else if (cmd.fail)
        begin
            low_next = mid_reg + THR_W'(1);
        end
        if (cmd.round_start)
        begin
            mid_next = low_reg + ((high_reg - low_reg) >> 1);
        end
    end

    always_comb
    begin
        rev_next        = rev_reg;
        visited_next    = visited_reg;
        depth_next      = depth_reg;
        seen_next       = seen_reg;
        j_next          = j_reg;
        eval_valid_next = cmd.scan_issue;
        eval_j_next     = j_reg;
        if (cmd.walk_start)
        begin
            rev_next     = cmd.walk_rev;
            visited_next = MAX_NODES'(1);
            depth_next   = NODE_W'(1);
            seen_next    = NODE_W'(1);
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - NODE_W'(1);
        end
        else if (push)
        begin
            visited_next[eval_j_reg] = 1'b1;
            depth_next               = depth_reg + NODE_W'(1);
            seen_next                = seen_reg + NODE_W'(1);
        end
        if (cmd.pop)
        begin
            j_next = '0;
        end
        else if (cmd.scan_issue)
        begin
            j_next = j_reg + NID_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        thr_next       = thr_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            thr_next       = low_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg <= '0;
            low_reg        <= '0;
            high_reg       <= mtsc_pkg::TOP_THRESHOLD;
            rev_reg        <= 1'b0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            seen_reg       <= '0;
            eval_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            load_index_reg <= load_index_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            rev_reg        <= rev_next;
            visited_reg    <= visited_next;
            depth_reg      <= depth_next;
            seen_reg       <= seen_next;
            eval_valid_reg <= eval_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg    <= mid_next;
        j_reg      <= j_next;
        eval_j_reg <= eval_j_next;
        thr_reg    <= thr_next;
    end

    assign status.round_done  = !(low_reg < high_reg);
    assign status.stack_empty = (depth_reg == '0);
    assign status.scan_last   = (NODE_W'(j_reg) == (nodes - NODE_W'(1)));
    assign status.walk_ok     = (seen_reg == nodes);
    assign status.rev_phase   = rev_reg;
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign threshold = thr_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mtsc_checker.sv =====
// Port-level checker for the min-threshold strong-connectivity core, with its bind.
`default_nettype none

module mtsc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          last_entry,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [mtsc_pkg::THR_W-1:0]    threshold
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(threshold))
        else $error("result word changed or dropped while stalled");

    // the final entry starts a search, so input is held off next cycle
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_entry |=> in_stall)
        else $error("input not stalled after final matrix entry");

    // a new result only comes out of a search
    a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a search");

    // a search ends by handing over its result
    a_search_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("search ended without a result word");

endmodule

bind min_threshold_strong_connectivity_core mtsc_checker u_mtsc_checker (.*);

`default_nettype wire
